// File: sv/assert_macros.svh
// Assertion helpers used by the packetizer top RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RIP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define RIP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RIP_ASSERT(lbl, clk, rstn, prop)
`define RIP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: sv/rip_pkg.sv
package rip_pkg;

    localparam int COUNT_W = 40;
    localparam int SCALE_W = 17;
    localparam int PROD_W  = COUNT_W + SCALE_W;
    localparam int TS_W    = 32;

    localparam logic [SCALE_W-1:0] RTP_CLOCK_HZ = 17'd90000;
    localparam logic [15:0] MAX_PAYLOAD = 16'd65523;
    localparam logic [15:0] RTP_HDR_LEN = 16'd12;
    localparam logic [7:0]  ILV_MAGIC   = 8'h24;
    localparam logic [7:0]  ILV_CHANNEL = 8'h00;
    localparam logic [7:0]  RTP_VER     = 8'h80;
    localparam logic [7:0]  RTP_PT      = 8'd96;
    localparam logic [4:0]  LAST_IDX    = 5'd16;

    localparam logic CFG_FRAME_RATE = 1'b0;
    localparam logic CFG_SOURCE_ID  = 1'b1;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] count;
        logic [7:0]         divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [TS_W-1:0] quot;
    } t_div_rsp;

endpackage

// File: sv/rip_muldiv.sv
module rip_muldiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rip_pkg::t_div_req i_req,
    output rip_pkg::t_div_rsp o_rsp
);
    import rip_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} t_state;

    t_state              r_state, n_state;
    logic [PROD_W-1:0]   r_acc, n_acc;
    logic [COUNT_W-1:0]  r_mcand, n_mcand;
    logic [7:0]          r_div, n_div;
    logic [7:0]          r_rem, n_rem;
    logic [5:0]          r_cnt, n_cnt;
    logic                r_done, n_done;
    logic [8:0]          trial;
    logic                ge;

    // One restoring step: bring in the next dividend bit and try the subtract.
    assign trial = {r_rem, r_acc[PROD_W-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_mcand = r_mcand;
        n_div   = r_div;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_state = S_MUL;
                    n_acc   = '0;
                    n_mcand = i_req.count;
                    n_div   = (i_req.divisor == 8'd0) ? 8'd1 : i_req.divisor;
                    n_cnt   = 6'(SCALE_W - 1);
                end
            end
            S_MUL: begin
                // Shift-and-add over the bits of the scale constant, MSB first.
                n_acc = {r_acc[PROD_W-2:0], 1'b0} +
                        (RTP_CLOCK_HZ[r_cnt[4:0]] ? PROD_W'(r_mcand) : '0);
                if (r_cnt == 6'd0) begin
                    n_state = S_DIV;
                    n_rem   = '0;
                    n_cnt   = 6'(PROD_W - 1);
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            S_DIV: begin
                n_rem = ge ? 8'(trial - {1'b0, r_div}) : trial[7:0];
                n_acc = {r_acc[PROD_W-2:0], ge};
                if (r_cnt == 6'd0) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
        r_div   <= n_div;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_acc[TS_W-1:0];

endmodule

// File: sv/rtp_interleaved_packetizer_top.sv
// RTP over RTSP interleaved packetizer. Payload bytes that continue a packet pass straight
// through, one word per cycle when the output is not stalled. The first byte of a packet
// starts the timestamp computation (frame count * 90000 / frame rate) in a shared
// shift-and-add / restoring-divide unit: 17 multiply steps and 57 divide steps, during
// which input is stalled. The 16 header words and the first payload byte then leave one
// per cycle when the output is not stalled, and only after that can the next word be
// taken. Configuration writes are always accepted and must only occur while idle.
`include "assert_macros.svh"

module rtp_interleaved_packetizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic [15:0] i_payload_size,
    input  logic [39:0] i_frame_num,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_end_of_run,
    output logic        o_out_end_of_frame,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import rip_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_EMIT} t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_frame_rate;
    logic [31:0] r_source_id;
    logic [15:0] r_seq, n_seq;
    logic [15:0] r_seq_cur, n_seq_cur;
    logic [15:0] r_left, n_left;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_data, n_data;
    logic [31:0] r_ts, n_ts;
    logic [4:0]  r_idx, n_idx;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_eor, n_out_eor;
    logic        r_out_eof, n_out_eof;

    t_div_req    div_req;
    t_div_rsp    div_rsp;
    logic        slot_free;
    logic        in_acc;
    logic [15:0] size_fix;
    logic [7:0]  hdr_byte;

    rip_muldiv u_muldiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && slot_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign size_fix = (i_payload_size == 16'd0) ? 16'd1 :
                      (i_payload_size > MAX_PAYLOAD) ? MAX_PAYLOAD : i_payload_size;

    assign div_req.start   = in_acc && i_first_byte;
    assign div_req.count   = i_frame_num;
    assign div_req.divisor = r_frame_rate;

    always_comb begin
        unique case (r_idx)
            5'd0:    hdr_byte = ILV_MAGIC;
            5'd1:    hdr_byte = ILV_CHANNEL;
            5'd2:    hdr_byte = r_len[15:8];
            5'd3:    hdr_byte = r_len[7:0];
            5'd4:    hdr_byte = RTP_VER;
            5'd5:    hdr_byte = RTP_PT;
            5'd6:    hdr_byte = r_seq_cur[15:8];
            5'd7:    hdr_byte = r_seq_cur[7:0];
            5'd8:    hdr_byte = r_ts[31:24];
            5'd9:    hdr_byte = r_ts[23:16];
            5'd10:   hdr_byte = r_ts[15:8];
            5'd11:   hdr_byte = r_ts[7:0];
            5'd12:   hdr_byte = r_source_id[31:24];
            5'd13:   hdr_byte = r_source_id[23:16];
            5'd14:   hdr_byte = r_source_id[15:8];
            5'd15:   hdr_byte = r_source_id[7:0];
            default: hdr_byte = r_data;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_seq       = r_seq;
        n_seq_cur   = r_seq_cur;
        n_left      = r_left;
        n_len       = r_len;
        n_data      = r_data;
        n_ts        = r_ts;
        n_idx       = r_idx;
        n_out_valid = slot_free ? 1'b0 : r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_eor   = r_out_eor;
        n_out_eof   = r_out_eof;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_first_byte) begin
                        n_state   = S_CALC;
                        n_seq_cur = r_seq;
                        n_seq     = r_seq + 16'd1;
                        n_len     = size_fix + RTP_HDR_LEN;
                        n_left    = size_fix - 16'd1;
                        n_data    = i_data_byte;
                        n_idx     = '0;
                    end else if (r_left != 16'd0) begin
                        // Continuation byte goes straight to the output register.
                        n_left      = r_left - 16'd1;
                        n_out_valid = 1'b1;
                        n_out_byte  = i_data_byte;
                        n_out_eor   = 1'b1;
                        n_out_eof   = (r_left == 16'd1);
                    end
                end
            end
            S_CALC: begin
                if (div_rsp.done) begin
                    n_ts    = div_rsp.quot;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = hdr_byte;
                    n_out_eor   = (r_idx == LAST_IDX);
                    n_out_eof   = (r_idx == LAST_IDX) && (r_left == 16'd0);
                    if (r_idx == LAST_IDX) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 5'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_seq        <= '0;
            r_left       <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
            r_frame_rate <= 8'd30;
            r_source_id  <= 32'd12345;
        end else begin
            r_state     <= n_state;
            r_seq       <= n_seq;
            r_left      <= n_left;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_FRAME_RATE: r_frame_rate <= i_cfg_data[7:0];
                    CFG_SOURCE_ID:  r_source_id  <= i_cfg_data;
                    default:        r_source_id  <= r_source_id;
                endcase
            end
        end
        r_seq_cur  <= n_seq_cur;
        r_len      <= n_len;
        r_data     <= n_data;
        r_ts       <= n_ts;
        r_out_byte <= n_out_byte;
        r_out_eor  <= n_out_eor;
        r_out_eof  <= n_out_eof;
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_byte         = r_out_byte;
    assign o_out_end_of_run   = r_out_eor;
    assign o_out_end_of_frame = r_out_eof;

    `RIP_ASSERT_NEXT(a_start_calc, i_clk, i_rst_n, in_acc && i_first_byte, r_state == S_CALC)
    `RIP_ASSERT(a_done_in_calc, i_clk, i_rst_n, div_rsp.done |-> (r_state == S_CALC))
    `RIP_ASSERT(a_eof_eor, i_clk, i_rst_n, (o_out_valid && o_out_end_of_frame) |-> o_out_end_of_run)
    `RIP_ASSERT(a_idx_range, i_clk, i_rst_n, r_idx <= LAST_IDX)

endmodule

// File: verif/rtp_interleaved_packetizer_checker.sv
module rtp_interleaved_packetizer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic [15:0] i_payload_size,
    input  logic [39:0] i_frame_num,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  o_out_byte,
    input  logic        o_out_end_of_run,
    input  logic        o_out_end_of_frame,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import rip_pkg::*;

    localparam logic [63:0] TICKS_PER_SEC  = 64'd90000;
    localparam logic [15:0] PAYLOAD_CAP    = 16'd65523;
    localparam logic [15:0] RTP_HEAD_BYTES = 16'd12;
    localparam logic [7:0]  MAGIC          = 8'h24;
    localparam logic [7:0]  CHANNEL        = 8'h00;
    localparam logic [7:0]  VERSION_BYTE   = 8'h80;
    localparam logic [7:0]  PAYLOAD_TYPE   = 8'd96;
    localparam logic [7:0]  RATE_AT_RESET  = 8'd30;
    localparam logic [31:0] SSRC_AT_RESET  = 32'd12345;
    localparam int          MAX_REPORTS    = 100;

    typedef struct packed {
        logic [7:0] value;
        logic       run_end;
        logic       frame_end;
    } t_frame_word;

    t_frame_word frame_q[$];

    logic [7:0]  rate;
    logic [31:0] ssrc;
    logic [15:0] next_seq;
    logic [15:0] payload_left;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic report_mismatch(input string msg);
        if (o_fail_count < MAX_REPORTS) begin
            $display("[%0t ns] mismatch: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    task automatic queue_word(input t_frame_word w);
        frame_q.insert(frame_q.size(), w);
    endtask

    // Builds the words that one accepted input word must produce.
    task automatic predict_frame_words(input logic [7:0] data, input logic first,
                                       input logic [15:0] size_in, input logic [39:0] count);
        logic [15:0]  size;
        logic [15:0]  frame_len;
        logic [7:0]   divisor;
        logic [63:0]  quotient;
        logic [127:0] head;
        int           i;
        if (first) begin
            if (size_in == 16'd0) begin
                size = 16'd1;
            end else if (size_in > PAYLOAD_CAP) begin
                size = PAYLOAD_CAP;
            end else begin
                size = size_in;
            end
            frame_len = size + RTP_HEAD_BYTES;
            divisor = (rate == 8'd0) ? 8'd1 : rate;
            quotient = ({24'd0, count} * TICKS_PER_SEC) / {56'd0, divisor};
            head = {MAGIC, CHANNEL, frame_len, VERSION_BYTE, PAYLOAD_TYPE, next_seq,
                    quotient[31:0], ssrc};
            for (i = 0; i < 16; i++) begin
                queue_word('{value: head[127 - 8*i -: 8], run_end: 1'b0, frame_end: 1'b0});
            end
            next_seq = next_seq + 16'd1;
            payload_left = size - 16'd1;
            queue_word('{value: data, run_end: 1'b1, frame_end: (payload_left == 16'd0)});
        end else if (payload_left != 16'd0) begin
            payload_left = payload_left - 16'd1;
            queue_word('{value: data, run_end: 1'b1, frame_end: (payload_left == 16'd0)});
        end
    endtask

    task automatic check_out_word();
        t_frame_word want;
        if (frame_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word %02h", o_out_byte));
            return;
        end
        want = frame_q.pop_front();
        o_checked++;
        if (o_out_byte !== want.value) begin
            report_mismatch($sformatf("byte %02h, expected %02h", o_out_byte, want.value));
        end
        if (o_out_end_of_run !== want.run_end) begin
            report_mismatch($sformatf("end_of_run %b, expected %b (byte %02h)",
                                      o_out_end_of_run, want.run_end, want.value));
        end
        if (o_out_end_of_frame !== want.frame_end) begin
            report_mismatch($sformatf("end_of_frame %b, expected %b (byte %02h)",
                                      o_out_end_of_frame, want.frame_end, want.value));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate         = RATE_AT_RESET;
            ssrc         = SSRC_AT_RESET;
            next_seq     = 16'd0;
            payload_left = 16'd0;
            frame_q.delete();
            o_pending   <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_FRAME_RATE) begin
                    rate = i_cfg_data[7:0];
                end else begin
                    ssrc = i_cfg_data;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                predict_frame_words(i_data_byte, i_first_byte, i_payload_size, i_frame_num);
            end
            if (o_out_valid && !i_out_stall) begin
                check_out_word();
            end
            // The stimulus side samples this at the clock edge, so it must not race.
            o_pending <= frame_q.size();
        end
    end

endmodule

// File: verif/rtp_interleaved_packetizer_top_test.sv
module rtp_interleaved_packetizer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rip_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 120;
    localparam int TARGET_WORDS  = 260;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_first_byte = 1'b0;
    logic [15:0] i_payload_size = 16'd0;
    logic [39:0] i_frame_num = 40'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_out_end_of_run;
    logic        o_out_end_of_frame;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = 32'd0;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int n_items = 0;
    int n_packets = 0;
    int n_stray = 0;
    int n_settings = 1;
    int tb_left = 0;
    bit steady = 1'b0;

    rtp_interleaved_packetizer_top dut (.*);

    rtp_interleaved_packetizer_checker checker_i (
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .*
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d words outstanding", cycle_count, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // Mostly short idle spans, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [39:0] rand_count();
        return 40'({$urandom, $urandom});
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] rand_size();
        return 16'($urandom);
    endfunction

    initial begin : out_pressure
        int hold;
        @(posedge i_clk);
        forever begin
            hold = pick_gap();
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(40, 120)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // Presents one input word and holds it until it is taken. Valid stays high
    // afterwards so that back-to-back words need not wait for valid to rise again.
    task automatic send_word(input logic [7:0] data, input logic first,
                             input logic [15:0] size, input logic [39:0] count);
        int gap;
        int eff;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= data;
        i_first_byte   <= first;
        i_payload_size <= size;
        i_frame_num    <= count;
        do @(posedge i_clk); while (o_in_stall);
        if (first) begin
            eff = (size == 16'd0) ? 1 : ((size > 16'd65523) ? 65523 : int'(size));
            tb_left = eff - 1;
            n_packets++;
            n_items++;
        end else if (tb_left > 0) begin
            tb_left--;
            n_items++;
        end else begin
            n_stray++;
        end
    endtask

    task automatic send_packet(input logic [15:0] size, input int words);
        send_word(rand_byte(), 1'b1, size, rand_count());
        repeat (words - 1) send_word(rand_byte(), 1'b0, rand_size(), rand_count());
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Holds off the sender until every predicted word has come out, then idles
    // a while longer before the next phase.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [7:0] rate;
        int         kind;
        int         sz;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset configuration.
        send_word(8'h5A, 1'b0, 16'hFFFF, 40'hFF_FFFF_FFFF);
        send_word(8'h00, 1'b1, 16'd3, 40'd0);
        send_word(8'hFF, 1'b0, 16'd0, 40'd0);
        send_word(8'h80, 1'b0, rand_size(), rand_count());
        send_word(8'h11, 1'b0, rand_size(), rand_count());
        send_word(8'hFF, 1'b1, 16'd0, 40'hFF_FFFF_FFFF);
        send_word(8'h01, 1'b1, 16'hFFFF, rand_count());
        send_word(rand_byte(), 1'b0, rand_size(), rand_count());
        send_word(rand_byte(), 1'b0, rand_size(), rand_count());
        // A new packet start abandons the rest of the saturated one.
        send_word(8'h7E, 1'b1, 16'd65523, 40'd1);
        send_word(rand_byte(), 1'b0, rand_size(), rand_count());
        send_word(8'hC3, 1'b1, 16'd1, 40'd29);
        send_word(8'h3C, 1'b1, 16'd2, 40'h55_AAAA_5555);
        send_word(8'hAA, 1'b0, 16'h5555, 40'hAA_5555_AAAA);
        drain();

        // A zero frame rate divides by one; the upper data bits are not part of it.
        write_reg(CFG_FRAME_RATE, 32'hFFFF_FF00);
        write_reg(CFG_SOURCE_ID, 32'h0000_0000);
        n_settings++;
        send_word(8'hA5, 1'b1, 16'd2, 40'hFF_FFFF_FFFF);
        send_word(8'h5A, 1'b0, rand_size(), rand_count());
        drain();

        write_reg(CFG_FRAME_RATE, 32'h0000_00FF);
        write_reg(CFG_SOURCE_ID, 32'hFFFF_FFFF);
        n_settings++;
        send_word(8'h0F, 1'b1, 16'd1, 40'hFF_FFFF_FFFF);
        drain();

        write_reg(CFG_FRAME_RATE, 32'd1);
        n_settings++;
        send_word(8'hF0, 1'b1, 16'd1, rand_count());
        drain();

        write_reg(CFG_FRAME_RATE, 32'd240);
        n_settings++;
        send_word(8'h96, 1'b1, 16'd1, 40'hFF_FFFF_FFFF);
        drain();

        // Random part: one setting per phase, mostly complete packets.
        while (n_items < TARGET_WORDS) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                rate = 8'd1;
            end else if (kind == 1) begin
                rate = 8'd240;
            end else begin
                rate = 8'($urandom_range(1, 240));
            end
            write_reg(CFG_FRAME_RATE, {24'($urandom), rate});
            write_reg(CFG_SOURCE_ID, $urandom);
            n_settings++;
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(3, 8)) begin
                kind = $urandom_range(0, 99);
                if (kind < 70) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_packet(16'($urandom_range(9, 65535)), $urandom_range(1, 5));
                    end else begin
                        sz = $urandom_range(1, 6);
                        send_packet(16'(sz), sz);
                    end
                end else if (kind < 80) begin
                    sz = $urandom_range(2, 8);
                    send_packet(16'(sz), $urandom_range(1, sz - 1));
                end else if (kind < 90) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_word(rand_byte(), 1'b0, rand_size(), rand_count());
                    end
                end else begin
                    send_packet(16'd0, 1);
                end
            end
            steady = 1'b0;
            drain();
        end

        $display("Sent %0d payload words in %0d packets plus %0d stray words, over %0d settings.",
                 n_items, n_packets, n_stray, n_settings);
        $display("Checked %0d output words against the predicted frames.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/rip_pkg.sv
sv/rip_muldiv.sv
sv/rtp_interleaved_packetizer_top.sv
verif/rtp_interleaved_packetizer_checker.sv
verif/rtp_interleaved_packetizer_top_test.sv
